// File: src/rth_pkg.sv
// Shared types, constants and divider step functions for the RGB to HSV core.
`timescale 1ns / 1ps
`default_nettype none
package rth_pkg;

  localparam int CH_W   = 8;   // channel width
  localparam int HUE_W  = 9;   // hue width, also hue quotient width
  localparam int HNUM_W = 17;  // hue dividend, up to 300 * 255
  localparam int SNUM_W = 16;  // saturation dividend, up to 255 * 255

  localparam logic [HNUM_W-1:0] K60  = HNUM_W'(60);
  localparam logic [HNUM_W-1:0] K120 = HNUM_W'(120);
  localparam logic [HNUM_W-1:0] K240 = HNUM_W'(240);
  localparam logic [HUE_W-1:0]  K360 = HUE_W'(360);
  localparam logic [CH_W-1:0]   K255 = CH_W'(255);

  // quotient bits resolved per divider stage; three stages in all
  localparam int HUE_STEPS_FIRST = 3;
  localparam int HUE_STEPS_MID   = 3;
  localparam int HUE_STEPS_LAST  = 3;
  localparam int SAT_STEPS_FIRST = 3;
  localparam int SAT_STEPS_MID   = 3;
  localparam int SAT_STEPS_LAST  = 2;

  // Word carried through the divider stages. rem holds the partial
  // remainder; lo holds the unused dividend bits on top and the quotient
  // bits shifted in from the bottom.
  typedef struct packed {
    logic            neg;     // red sector with green below blue
    logic [CH_W-1:0] bright;
    logic [CH_W-1:0] h_den;
    logic [CH_W-1:0] h_rem;
    logic [HUE_W-1:0] h_lo;
    logic [CH_W-1:0] s_den;
    logic [CH_W-1:0] s_rem;
    logic [CH_W-1:0] s_lo;
  } div_t;

  // One restoring step of the hue division.
  function automatic div_t hue_step(div_t w);
    logic [CH_W:0] t;
    div_t r;
    r = w;
    t = {w.h_rem, w.h_lo[HUE_W-1]};
    if (t >= {1'b0, w.h_den}) begin
      r.h_rem = CH_W'(t - {1'b0, w.h_den});
      r.h_lo  = {w.h_lo[HUE_W-2:0], 1'b1};
    end else begin
      r.h_rem = t[CH_W-1:0];
      r.h_lo  = {w.h_lo[HUE_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // One restoring step of the saturation division.
  function automatic div_t sat_step(div_t w);
    logic [CH_W:0] t;
    div_t r;
    r = w;
    t = {w.s_rem, w.s_lo[CH_W-1]};
    if (t >= {1'b0, w.s_den}) begin
      r.s_rem = CH_W'(t - {1'b0, w.s_den});
      r.s_lo  = {w.s_lo[CH_W-2:0], 1'b1};
    end else begin
      r.s_rem = t[CH_W-1:0];
      r.s_lo  = {w.s_lo[CH_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/rth_front.sv
// Front end: max/min and sector pick, then hue and saturation dividends.
`timescale 1ns / 1ps
`default_nettype none
module rth_front
  import rth_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [CH_W-1:0] red,
  input  wire logic [CH_W-1:0] green,
  input  wire logic [CH_W-1:0] blue,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output div_t                 out_word
);

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2,
    SEC_GRAY  = 2'd3
  } sector_t;

  // stage 1 registers
  logic                    v1;
  sector_t                 s1_sec;
  logic [CH_W-1:0]         s1_mx;
  logic [CH_W-1:0]         s1_d;
  logic signed [CH_W:0]    s1_diff;

  // stage 2 registers
  logic                    v2;
  div_t                    s2_word;

  logic                    ready1;
  logic                    ready2;

  sector_t                 sec_c;
  logic [CH_W-1:0]         mx_c;
  logic [CH_W-1:0]         mn_c;
  logic signed [CH_W:0]    diff_c;

  div_t                    word_c;
  logic [CH_W:0]           neg_diff;
  logic [CH_W-1:0]         mag;
  logic [HNUM_W-1:0]       base;
  logic signed [HNUM_W:0]  d60;
  logic signed [HNUM_W:0]  sum;
  logic [HNUM_W-1:0]       hnum;
  logic [SNUM_W-1:0]       snum;
  logic                    gray;

  assign ready2   = !v2 || out_ready;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  always_comb begin
    mx_c = red;
    if (green > mx_c) mx_c = green;
    if (blue > mx_c) mx_c = blue;
    mn_c = red;
    if (green < mn_c) mn_c = green;
    if (blue < mn_c) mn_c = blue;

    // tie order: red over green, green over blue, blue over red
    if (red > green) begin
      sec_c = (red > blue) ? SEC_RED : SEC_BLUE;
    end else if (green > blue) begin
      sec_c = (green > red) ? SEC_GREEN : SEC_RED;
    end else if (blue > red) begin
      sec_c = (blue > green) ? SEC_BLUE : SEC_GREEN;
    end else begin
      sec_c = SEC_GRAY;
    end

    case (sec_c)
      SEC_RED:   diff_c = $signed({1'b0, green}) - $signed({1'b0, blue});
      SEC_GREEN: diff_c = $signed({1'b0, blue}) - $signed({1'b0, red});
      SEC_BLUE:  diff_c = $signed({1'b0, red}) - $signed({1'b0, green});
      default:   diff_c = '0;
    endcase
  end

  always_comb begin
    gray     = (s1_sec == SEC_GRAY);
    neg_diff = (CH_W+1)'(-s1_diff);
    mag      = s1_diff[CH_W] ? neg_diff[CH_W-1:0] : s1_diff[CH_W-1:0];
    d60      = (HNUM_W+1)'(s1_diff) * $signed({1'b0, K60});
    case (s1_sec)
      SEC_GREEN: base = {{(HNUM_W-CH_W){1'b0}}, s1_d} * K120;
      SEC_BLUE:  base = {{(HNUM_W-CH_W){1'b0}}, s1_d} * K240;
      default:   base = '0;
    endcase
    sum = $signed({1'b0, base}) + d60;

    case (s1_sec)
      SEC_RED:   hnum = {{(HNUM_W-CH_W){1'b0}}, mag} * K60;
      SEC_GREEN: hnum = sum[HNUM_W-1:0];
      SEC_BLUE:  hnum = sum[HNUM_W-1:0];
      default:   hnum = '0;
    endcase
    snum = {s1_d, {CH_W{1'b0}}} - {{CH_W{1'b0}}, s1_d};

    word_c.neg    = (s1_sec == SEC_RED) && s1_diff[CH_W];
    word_c.bright = s1_mx;
    // gray: dividends are zero, divisors forced to one
    word_c.h_den  = gray ? CH_W'(1) : s1_d;
    word_c.h_rem  = hnum[HNUM_W-1:HUE_W];
    word_c.h_lo   = hnum[HUE_W-1:0];
    word_c.s_den  = gray ? CH_W'(1) : s1_mx;
    word_c.s_rem  = snum[SNUM_W-1:CH_W];
    word_c.s_lo   = snum[CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (ready1) v1 <= in_valid;
      if (ready2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      s1_sec  <= sec_c;
      s1_mx   <= mx_c;
      s1_d    <= mx_c - mn_c;
      s1_diff <= diff_c;
    end
    if (ready2 && v1) begin
      s2_word <= word_c;
    end
  end

  assign out_valid = v2;
  assign out_word  = s2_word;

endmodule
`default_nettype wire

// File: src/rth_div_stage.sv
// One pipelined divider stage: a few restoring steps of both divisions.
`timescale 1ns / 1ps
`default_nettype none
module rth_div_stage
  import rth_pkg::*;
#(
  parameter int HUE_STEPS = HUE_STEPS_MID,
  parameter int SAT_STEPS = SAT_STEPS_MID
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire div_t in_word,
  output logic      out_valid,
  input  wire logic out_ready,
  output div_t      out_word
);

  logic v;
  div_t word;
  div_t word_next;

  assign in_ready = !v || out_ready;

  always_comb begin
    word_next = in_word;
    for (int i = 0; i < HUE_STEPS; i++) begin
      word_next = hue_step(word_next);
    end
    for (int i = 0; i < SAT_STEPS; i++) begin
      word_next = sat_step(word_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word <= word_next;
    end
  end

  assign out_valid = v;
  assign out_word  = word;

endmodule
`default_nettype wire

// File: src/rgb_to_hsv_pixel_core.sv
// Top level of the pipelined RGB to HSV pixel converter.
`timescale 1ns / 1ps
`default_nettype none
// Converts one 8-bit RGB pixel to hue (0..359 degrees), saturation
// (0..255) and brightness (the largest channel) with exact integer
// division; gray pixels give hue and saturation of 0. The core takes one
// pixel per clock while the output is not stalled. Two front stages pick
// the largest channel and build the dividends, three stages each resolve
// three quotient bits of the hue division and three, three and two bits of
// the saturation division, and the last stage wraps negative red-sector
// hues and holds the output word. Every stage keeps its own valid bit, so
// a stall on the output fills bubbles first and then backs up to in_ready
// without dropping a word.
module rgb_to_hsv_pixel_core
  import rth_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [CH_W-1:0]  red,
  input  wire logic [CH_W-1:0]  green,
  input  wire logic [CH_W-1:0]  blue,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [HUE_W-1:0]      hue,
  output logic [CH_W-1:0]       saturation,
  output logic [CH_W-1:0]       brightness
);

  logic f_valid, f_ready;
  logic a_valid, a_ready;
  logic b_valid, b_ready;
  logic c_valid, c_ready;
  div_t f_word, a_word, b_word, c_word;

  logic             ov;
  logic [HUE_W-1:0] q;
  logic [HUE_W-1:0] hue_next;

  rth_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_word  (f_word)
  );

  rth_div_stage #(
    .HUE_STEPS (HUE_STEPS_FIRST),
    .SAT_STEPS (SAT_STEPS_FIRST)
  ) u_div0 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_word   (f_word),
    .out_valid (a_valid),
    .out_ready (a_ready),
    .out_word  (a_word)
  );

  rth_div_stage #(
    .HUE_STEPS (HUE_STEPS_MID),
    .SAT_STEPS (SAT_STEPS_MID)
  ) u_div1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_valid),
    .in_ready  (a_ready),
    .in_word   (a_word),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_word  (b_word)
  );

  rth_div_stage #(
    .HUE_STEPS (HUE_STEPS_LAST),
    .SAT_STEPS (SAT_STEPS_LAST)
  ) u_div2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_valid),
    .in_ready  (b_ready),
    .in_word   (b_word),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_word  (c_word)
  );

  assign c_ready = !ov || out_ready;

  // red sector truncates toward zero, so a negative nonzero quotient wraps
  always_comb begin
    q = c_word.h_lo;
    if (c_word.neg && (q != '0)) begin
      hue_next = K360 - q;
    end else begin
      hue_next = q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (c_ready) begin
      ov <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && c_valid) begin
      hue        <= hue_next;
      saturation <= c_word.s_lo;
      brightness <= c_word.bright;
    end
  end

  assign out_valid = ov;

endmodule
`default_nettype wire

// File: src/rth_checker.sv
// Port-level checker for the RGB to HSV core and its bind.
`timescale 1ns / 1ps
`default_nettype none
module rth_checker
  import rth_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [HUE_W-1:0] hue,
  input wire logic [CH_W-1:0]  saturation,
  input wire logic [CH_W-1:0]  brightness
);

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set right after reset");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hue < K360))
    else $error("hue out of range");

  // zero saturation only for gray, and gray has zero hue
  a_gray_hue: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (saturation == '0)) |-> (hue == '0))
    else $error("nonzero hue with zero saturation");

  a_black: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (brightness == '0)) |-> (saturation == '0))
    else $error("nonzero saturation on black word");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(hue) && $stable(saturation) && $stable(brightness)))
    else $error("output word changed while stalled");

endmodule

bind rgb_to_hsv_pixel_core rth_checker u_rth_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .hue        (hue),
  .saturation (saturation),
  .brightness (brightness)
);
`default_nettype wire
